/* src/grbb_pkg.sv */
// Shared types and constants for the glyph region bounding box block.
// Used by the channel interfaces and the top level; depends on nothing else.
package grbb_pkg;

  localparam int COLOR_W  = 32;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int SEQ_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [COLOR_W-1:0] BORDER_RESET = 32'hFF00FFFF;
  localparam logic [DIM_W-1:0]   DIM_RESET    = 9'd256;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND      = 2'd0,
    ST_DONE       = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BORDER = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_index_e;

endpackage

/* src/grbb_req_if.sv */
// Request channel of the glyph region bounding box block: valid/ready plus
// the pixel load or region request fields. Depends on grbb_pkg.
interface grbb_req_if import grbb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COLOR_W-1:0] pixel_color;
  logic               first_pixel;

  modport source(output valid, opcode, pixel_color, first_pixel, input ready);
  modport sink(input valid, opcode, pixel_color, first_pixel, output ready);
endinterface

/* src/grbb_rsp_if.sv */
// Result channel of the glyph region bounding box block: valid/ready plus
// the region rectangle and status fields. Depends on grbb_pkg.
interface grbb_rsp_if import grbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0]  rect_x;
  logic [COORD_W-1:0]  rect_y;
  logic [SIZE_W-1:0]   rect_width;
  logic [SIZE_W-1:0]   rect_height;
  logic [SEQ_W-1:0]    region_index;

  modport source(output valid, status, rect_x, rect_y, rect_width, rect_height,
                 region_index, input ready);
  modport sink(input valid, status, rect_x, rect_y, rect_width, rect_height,
               region_index, output ready);
endinterface

/* src/glyph_region_bounding_boxes.sv */
// Top level of the glyph region bounding box block: pixel store, scan sequencer
// and APB register file. Depends on grbb_pkg, grbb_req_if and grbb_rsp_if.
//
// A pixel load (opcode 0) is taken in the idle state and the sequencer stays
// idle, so loads stream at one per cycle while no result waits untaken in the
// output register. A region request on an incomplete image, or when the scan
// is already at its end, is answered straight from the idle state. Otherwise
// a bit-serial divider over IDX_W bits (17 with the default 256 x 256 maximum)
// turns the resume position into column and row; the search then reads and
// checks each pixel in turn (S_SREAD, S_SCHK), and the region walk reads and
// checks each pixel of the region and any border pixel that stops a row (S_WREAD,
// S_WCHK). Each step reads the single pixel memory once, with a registered read.
// No request is taken while one is in progress. A result waits in an output
// register, and the next request is taken in the cycle in which that result is taken.
module glyph_region_bounding_boxes import grbb_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  grbb_req_if.sink    req_i,
  grbb_rsp_if.source  rsp_o
);

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int IDX_W  = $clog2(PIXELS + 1);
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SREAD,
    S_SCHK,
    S_WREAD,
    S_WCHK
  } state_e;

  state_e              state_q, state_d;
  logic [COLOR_W-1:0]  border_q, border_d;
  logic [DIM_W-1:0]    width_q, width_d;
  logic [DIM_W-1:0]    height_q, height_d;
  logic [IDX_W-1:0]    load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]    scan_pos_q, scan_pos_d;
  logic [SEQ_W-1:0]    region_cnt_q, region_cnt_d;
  logic [IDX_W-1:0]    div_q, div_d;
  logic [W_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    row_idx_q, row_idx_d;
  logic [W_W-1:0]      cur_x_q, cur_x_d;
  logic [H_W-1:0]      cur_y_q, cur_y_d;
  logic [W_W-1:0]      sx_q, sx_d;
  logic [H_W-1:0]      sy_q, sy_d;
  logic [W_W-1:0]      rw_q, rw_d;
  logic [H_W-1:0]      rh_q, rh_d;
  logic                rsp_valid_q, rsp_valid_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [COORD_W-1:0]  rsp_x_q, rsp_x_d;
  logic [COORD_W-1:0]  rsp_y_q, rsp_y_d;
  logic [SIZE_W-1:0]   rsp_w_q, rsp_w_d;
  logic [SIZE_W-1:0]   rsp_h_q, rsp_h_d;
  logic [SEQ_W-1:0]    rsp_idx_q, rsp_idx_d;

  logic [1:0]          pix_mem [PIXELS];
  logic [1:0]          mem_rd_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [1:0]          mem_wdata;

  logic [W_W-1:0]      eff_w;
  logic [H_W-1:0]      eff_h;
  logic [IDX_W-1:0]    total;
  logic                req_fire;
  logic                cfg_we;
  logic [IDX_W-1:0]    load_base;
  logic [W_W:0]        x_inc;
  logic [H_W:0]        y_inc;
  logic                x_last;
  logic                y_last;
  logic [IDX_W-1:0]    idx_inc;
  logic [W_W:0]        rem_sh;
  logic                rem_ge;
  logic                end_row;
  logic                end_region;

  always_comb begin
    if (width_q == '0) begin
      eff_w = W_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = H_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = H_W'(MAX_HEIGHT);
    end else begin
      eff_h = H_W'(height_q);
    end
  end

  assign total = IDX_W'(IDX_W'(eff_w) * IDX_W'(eff_h));

  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite;
  assign req_i.ready   = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_fire      = req_i.valid && req_i.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.rect_x       = rsp_x_q;
  assign rsp_o.rect_y       = rsp_y_q;
  assign rsp_o.rect_width   = rsp_w_q;
  assign rsp_o.rect_height  = rsp_h_q;
  assign rsp_o.region_index = rsp_idx_q;

  always_comb begin
    unique case (paddr[3:2])
      REG_BORDER: prdata = border_q;
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign load_base = req_i.first_pixel ? '0 : load_cnt_q;
  assign x_inc     = {1'b0, cur_x_q} + (W_W + 1)'(1);
  assign y_inc     = {1'b0, cur_y_q} + (H_W + 1)'(1);
  assign x_last    = (x_inc == {1'b0, eff_w});
  assign y_last    = (y_inc == {1'b0, eff_h});
  assign idx_inc   = idx_q + IDX_W'(1);
  assign rem_sh    = {rem_q, div_q[IDX_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, eff_w});

  always_comb begin
    state_d      = state_q;
    border_d     = border_q;
    width_d      = width_q;
    height_d     = height_q;
    load_cnt_d   = load_cnt_q;
    scan_pos_d   = scan_pos_q;
    region_cnt_d = region_cnt_q;
    div_d        = div_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    idx_d        = idx_q;
    row_idx_d    = row_idx_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_x_d      = rsp_x_q;
    rsp_y_d      = rsp_y_q;
    rsp_w_d      = rsp_w_q;
    rsp_h_d      = rsp_h_q;
    rsp_idx_d    = rsp_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_wdata    = 2'b11;
    end_row      = 1'b0;
    end_region   = 1'b0;

    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BORDER: border_d = pwdata;
        REG_WIDTH:  width_d  = pwdata[DIM_W-1:0];
        REG_HEIGHT: height_d = pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.opcode == OP_LOAD) begin
            if (req_i.first_pixel) begin
              scan_pos_d   = '0;
              region_cnt_d = '0;
            end
            load_cnt_d = load_base;
            if (load_base < total) begin
              mem_we     = 1'b1;
              mem_waddr  = load_base[AW-1:0];
              mem_wdata  = {req_i.pixel_color != border_q, 1'b0};
              load_cnt_d = load_base + IDX_W'(1);
            end
          end else if (load_cnt_q < total) begin
            rsp_valid_d  = 1'b1;
            rsp_status_d = ST_INCOMPLETE;
            rsp_x_d      = '0;
            rsp_y_d      = '0;
            rsp_w_d      = '0;
            rsp_h_d      = '0;
            rsp_idx_d    = '0;
          end else if (scan_pos_q >= total) begin
            scan_pos_d   = total;
            rsp_valid_d  = 1'b1;
            rsp_status_d = ST_DONE;
            rsp_x_d      = '0;
            rsp_y_d      = '0;
            rsp_w_d      = '0;
            rsp_h_d      = '0;
            rsp_idx_d    = '0;
          end else begin
            div_d     = scan_pos_q;
            rem_d     = '0;
            div_cnt_d = CNT_W'(IDX_W - 1);
            idx_d     = scan_pos_q;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d     = rem_ge ? W_W'(rem_sh - {1'b0, eff_w}) : rem_sh[W_W-1:0];
        div_d     = (div_q << 1) | IDX_W'(rem_ge);
        div_cnt_d = div_cnt_q - CNT_W'(1);
        if (div_cnt_q == '0) begin
          cur_x_d = rem_d;
          cur_y_d = H_W'(div_d);
          state_d = S_SREAD;
        end
      end
      S_SREAD: begin
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (mem_rd_q[1] && !mem_rd_q[0]) begin
          sx_d       = cur_x_q;
          sy_d       = cur_y_q;
          row_idx_d  = idx_q;
          rw_d       = W_W'(1);
          rh_d       = H_W'(1);
          scan_pos_d = idx_inc;
          state_d    = S_WREAD;
        end else if (idx_inc >= total) begin
          scan_pos_d   = total;
          rsp_valid_d  = 1'b1;
          rsp_status_d = ST_DONE;
          rsp_x_d      = '0;
          rsp_y_d      = '0;
          rsp_w_d      = '0;
          rsp_h_d      = '0;
          rsp_idx_d    = '0;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_inc;
          if (x_last) begin
            cur_x_d = '0;
            cur_y_d = y_inc[H_W-1:0];
          end else begin
            cur_x_d = x_inc[W_W-1:0];
          end
          state_d = S_SREAD;
        end
      end
      S_WREAD: begin
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if (mem_rd_q[1]) begin
          mem_we = 1'b1;
          rw_d   = cur_x_q - sx_q + W_W'(1);
          rh_d   = cur_y_q - sy_q + H_W'(1);
          if (x_last) begin
            end_row = 1'b1;
          end else begin
            cur_x_d = x_inc[W_W-1:0];
            idx_d   = idx_inc;
            state_d = S_WREAD;
          end
        end else if (cur_x_q == sx_q) begin
          end_region = 1'b1;
        end else begin
          end_row = 1'b1;
        end
        if (end_row) begin
          if (y_last) begin
            end_region = 1'b1;
          end else begin
            cur_y_d   = y_inc[H_W-1:0];
            cur_x_d   = sx_q;
            row_idx_d = row_idx_q + IDX_W'(eff_w);
            idx_d     = row_idx_q + IDX_W'(eff_w);
            state_d   = S_WREAD;
          end
        end
        if (end_region) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = ST_FOUND;
          rsp_x_d      = COORD_W'(sx_q);
          rsp_y_d      = COORD_W'(sy_q);
          rsp_w_d      = SIZE_W'(rw_d);
          rsp_h_d      = SIZE_W'(rh_d);
          rsp_idx_d    = region_cnt_q;
          region_cnt_d = region_cnt_q + SEQ_W'(1);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      border_q     <= BORDER_RESET;
      width_q      <= DIM_RESET;
      height_q     <= DIM_RESET;
      load_cnt_q   <= '0;
      scan_pos_q   <= '0;
      region_cnt_q <= '0;
      div_cnt_q    <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      border_q     <= border_d;
      width_q      <= width_d;
      height_q     <= height_d;
      load_cnt_q   <= load_cnt_d;
      scan_pos_q   <= scan_pos_d;
      region_cnt_q <= region_cnt_d;
      div_cnt_q    <= div_cnt_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q        <= div_d;
    rem_q        <= rem_d;
    idx_q        <= idx_d;
    row_idx_q    <= row_idx_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    sx_q         <= sx_d;
    sy_q         <= sy_d;
    rw_q         <= rw_d;
    rh_q         <= rh_d;
    rsp_status_q <= rsp_status_d;
    rsp_x_q      <= rsp_x_d;
    rsp_y_q      <= rsp_y_d;
    rsp_w_q      <= rsp_w_d;
    rsp_h_q      <= rsp_h_d;
    rsp_idx_q    <= rsp_idx_d;
  end

  // Each entry holds the foreground bit above the visited bit. A load writes
  // the visited bit as zero, so a new image needs no separate clearing pass.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= pix_mem[idx_q[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_load_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= IDX_W'(PIXELS))
    else $error("Load count ran past the pixel store.");

  a_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !req_fire) |=> state_q == S_IDLE)
    else $error("Sequencer left idle without a request.");

  a_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.opcode == OP_SCAN && load_cnt_q < total)
    |=> (rsp_valid_q && rsp_status_q == ST_INCOMPLETE))
    else $error("Request on an incomplete image did not report it.");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WCHK |-> idx_q == row_idx_q + IDX_W'(cur_x_q - sx_q))
    else $error("Walk index lost track of the column.");

  a_found_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q == ST_FOUND) |-> (rsp_w_q != '0 && rsp_h_q != '0))
    else $error("Found region has an empty size.");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for glyph_region_bounding_boxes: streams images and region
// requests, predicts every bounding box from its own pixel masks and checks each result.
// Depends on grbb_pkg, grbb_req_if, grbb_rsp_if and the top level of the block.
module testbench import grbb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM       = 256;
  localparam int PIXELS        = MAX_DIM * MAX_DIM;
  localparam int RUN_ITEMS     = 1110;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int IDLE_PCT      = 11;

  typedef struct packed {
    opcode_e            op;
    logic [COLOR_W-1:0] color;
    logic               first;
  } pixel_req_t;

  typedef struct packed {
    status_e            status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [SEQ_W-1:0]   seq;
  } box_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grbb_req_if req_bus ();
  grbb_rsp_if rsp_bus ();

  glyph_region_bounding_boxes i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus)
  );

  pixel_req_t  pending_requests[$];
  box_result_t expected_boxes[$];
  pixel_req_t  on_bus;

  bit               pixel_is_ink [PIXELS];
  bit               pixel_claimed [PIXELS];
  int               pixels_loaded;
  int               resume_pos;
  logic [SEQ_W-1:0] regions_found;
  logic [COLOR_W-1:0] cfg_border;
  logic [DIM_W-1:0]   cfg_width;
  logic [DIM_W-1:0]   cfg_height;

  int fail_count;
  int cycle_count;
  int items_queued;
  int req_idle_pct;
  int rsp_idle_pct;
  bit hold_start;
  bit stall_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  task automatic predict_box(input pixel_req_t it);
    int w, h, total, pos, sx, sy, x, y, rw, rh, i;
    box_result_t r;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    total = w * h;
    if (it.op == OP_LOAD) begin
      if (it.first) begin
        for (i = 0; i < PIXELS; i++) pixel_claimed[i] = 1'b0;
        pixels_loaded = 0;
        resume_pos = 0;
        regions_found = '0;
      end
      if (pixels_loaded < total) begin
        pixel_is_ink[pixels_loaded] = (it.color != cfg_border);
        pixels_loaded++;
      end
      return;
    end
    r = '0;
    if (pixels_loaded < total) begin
      r.status = ST_INCOMPLETE;
      expected_boxes.push_back(r);
      return;
    end
    pos = resume_pos;
    while (pos < total && !(pixel_is_ink[pos] && !pixel_claimed[pos])) pos++;
    if (pos >= total) begin
      resume_pos = total;
      r.status = ST_DONE;
      expected_boxes.push_back(r);
      return;
    end
    sx = pos % w;
    sy = pos / w;
    rw = 1;
    rh = 1;
    for (y = sy; y < h; y++) begin
      if (!pixel_is_ink[sx + y * w]) break;
      for (x = sx; x < w; x++) begin
        if (!pixel_is_ink[x + y * w]) break;
        pixel_claimed[x + y * w] = 1'b1;
        rw = x - sx + 1;
        rh = y - sy + 1;
      end
    end
    resume_pos = pos + 1;
    r.status = ST_FOUND;
    r.x = sx[COORD_W-1:0];
    r.y = sy[COORD_W-1:0];
    r.width = rw[SIZE_W-1:0];
    r.height = rh[SIZE_W-1:0];
    r.seq = regions_found;
    regions_found = regions_found + 1'b1;
    expected_boxes.push_back(r);
  endtask

  always @(posedge clk_i) begin : drive_requests
    bit offered;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        predict_box(on_bus);
        offered = 1'b0;
      end else begin
        offered = req_bus.valid;
      end
      if (!offered) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
          on_bus = pending_requests.pop_front();
          req_bus.valid       <= 1'b1;
          req_bus.opcode      <= on_bus.op;
          req_bus.pixel_color <= on_bus.color;
          req_bus.first_pixel <= on_bus.first;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    box_result_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_boxes.size() == 0) begin
          $error("unexpected result: status %0d", rsp_bus.status);
          fail_count++;
        end else begin
          want = expected_boxes.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.rect_x !== want.x) begin
            $error("rect_x: expected %0d, actual %0d", want.x, rsp_bus.rect_x);
            fail_count++;
          end
          if (rsp_bus.rect_y !== want.y) begin
            $error("rect_y: expected %0d, actual %0d", want.y, rsp_bus.rect_y);
            fail_count++;
          end
          if (rsp_bus.rect_width !== want.width) begin
            $error("rect_width: expected %0d, actual %0d", want.width, rsp_bus.rect_width);
            fail_count++;
          end
          if (rsp_bus.rect_height !== want.height) begin
            $error("rect_height: expected %0d, actual %0d", want.height,
                   rsp_bus.rect_height);
            fail_count++;
          end
          if (rsp_bus.region_index !== want.seq) begin
            $error("region_index: expected %0d, actual %0d", want.seq,
                   rsp_bus.region_index);
            fail_count++;
          end
        end
      end
      rsp_bus.ready <= !stall_hold && ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  initial begin : receiver_holdoff
    wait (hold_start);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("glyph_region_bounding_boxes regression: fail");
    $finish;
  end

  task automatic reg_write(input reg_index_e idx, input logic [31:0] data);
    logic [31:0] stored;
    stored = '0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_BORDER: begin
        cfg_border = data;
        stored = data;
      end
      REG_WIDTH: begin
        cfg_width = data[DIM_W-1:0];
        stored[DIM_W-1:0] = data[DIM_W-1:0];
      end
      REG_HEIGHT: begin
        cfg_height = data[DIM_W-1:0];
        stored[DIM_W-1:0] = data[DIM_W-1:0];
      end
      default: begin
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== stored) begin
      $error("prdata: expected %0h, actual %0h", stored, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input logic [31:0] border, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h);
    logic [31:0] data;
    reg_write(REG_BORDER, border);
    data = $urandom;
    data[DIM_W-1:0] = w;
    reg_write(REG_WIDTH, data);
    data = $urandom;
    data[DIM_W-1:0] = h;
    reg_write(REG_HEIGHT, data);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_bus.valid || expected_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_item(input opcode_e op, input logic [31:0] color, input logic first);
    pixel_req_t it;
    it.op = op;
    it.color = color;
    it.first = first;
    pending_requests.push_back(it);
    items_queued++;
  endtask

  task automatic queue_scans(input int n);
    int i;
    for (i = 0; i < n; i++) push_item(OP_SCAN, $urandom, 1'($urandom_range(1)));
  endtask

  function automatic logic [31:0] ink_color(input logic [31:0] border);
    logic [31:0] c;
    if ($urandom_range(7) == 0) return border ^ (32'h1 << $urandom_range(31));
    c = $urandom;
    if (c == border) c = c ^ 32'h1;
    return c;
  endfunction

  function automatic logic [31:0] pick_border();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return BORDER_RESET;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_image(input int w, input int h, input bit gridded,
                             input logic [31:0] border, output int ink);
    bit col_line [MAX_DIM];
    bit row_line [MAX_DIM];
    bit fg;
    int x, y;
    ink = 0;
    for (x = 0; x < w; x++) col_line[x] = ($urandom_range(3) == 0);
    for (y = 0; y < h; y++) row_line[y] = ($urandom_range(3) == 0);
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        if (gridded) fg = !(row_line[y] || col_line[x]) ^ ($urandom_range(19) == 0);
        else fg = ($urandom_range(9) < 6);
        if (fg) ink++;
        if (x + y > 0 && $urandom_range(49) == 0) queue_scans(1);
        push_item(OP_LOAD, fg ? ink_color(border) : border,
                  (x == 0 && y == 0) || ($urandom_range(299) == 0));
      end
    end
  endtask

  task automatic random_phase(input int w, input int h);
    logic [31:0] border;
    int ink, n, i;
    border = pick_border();
    set_geometry(border, w[DIM_W-1:0], h[DIM_W-1:0]);
    queue_image(w, h, $urandom_range(2) != 0, border, ink);
    n = (ink + 1) / 2 + $urandom_range(1, 3);
    if ($urandom_range(3) == 0) n = $urandom_range(1, n);
    queue_scans(n);
    if ($urandom_range(2) == 0) begin
      for (i = 0; i < $urandom_range(1, 2); i++)
        push_item(OP_LOAD, ink_color(border), 1'b0);
      queue_scans($urandom_range(1, 2));
    end
    if ($urandom_range(3) == 0) begin
      queue_image(w, h, 1'b1, border, ink);
      queue_scans((ink + 1) / 2 + 2);
    end
  endtask

  initial begin : stimulus
    int x, ink;
    logic [31:0] border;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_LOAD;
    req_bus.pixel_color = '0;
    req_bus.first_pixel = 1'b0;
    rsp_bus.ready = 1'b0;
    cfg_border = BORDER_RESET;
    cfg_width = DIM_RESET;
    cfg_height = DIM_RESET;
    pixels_loaded = 0;
    resume_pos = 0;
    regions_found = '0;
    fail_count = 0;
    cycle_count = 0;
    items_queued = 0;
    req_idle_pct = IDLE_PCT;
    rsp_idle_pct = IDLE_PCT;
    hold_start = 1'b0;
    stall_hold = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A request straight after reset finds the full-size image unloaded.
    push_item(OP_SCAN, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Small image loaded from the reset state, with an early request and an excess load.
    set_geometry(32'h0000_0000, 9'd3, 9'd2);
    push_item(OP_LOAD, 32'h0000_0000, 1'b0);
    push_item(OP_LOAD, 32'h0000_0001, 1'b0);
    push_item(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
    push_item(OP_SCAN, 32'h0000_0000, 1'b0);
    push_item(OP_LOAD, 32'h8000_0000, 1'b0);
    push_item(OP_LOAD, 32'h7FFF_FFFF, 1'b0);
    push_item(OP_LOAD, 32'h0000_0000, 1'b0);
    push_item(OP_LOAD, 32'h1234_5678, 1'b0);
    queue_scans(2);
    push_item(OP_SCAN, 32'h0000_0000, 1'b0);
    push_item(OP_SCAN, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Zero width reads as one column; then a fresh image made of border only.
    set_geometry(32'hFFFF_FFFF, 9'd0, 9'd1);
    push_item(OP_LOAD, 32'hFFFF_FFFE, 1'b1);
    queue_scans(2);
    push_item(OP_LOAD, 32'hFFFF_FFFF, 1'b1);
    push_item(OP_SCAN, 32'h0000_0000, 1'b1);
    wait_drained();

    // Widest row, with the width register above the maximum.
    border = pick_border();
    set_geometry(border, 9'd511, 9'd1);
    for (x = 0; x < MAX_DIM; x++)
      push_item(OP_LOAD, (x == 127 || x == 254) ? border : ink_color(border), x == 0);
    queue_scans(4);
    wait_drained();

    // Tallest column, solid, streamed with no idling on either side.
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    border = pick_border();
    set_geometry(border, 9'd1, 9'd300);
    for (x = 0; x < MAX_DIM; x++) push_item(OP_LOAD, ink_color(border), x == 0);
    queue_scans(2);
    wait_drained();
    req_idle_pct = IDLE_PCT;
    rsp_idle_pct = IDLE_PCT;

    // The receiver holds off while a burst of requests backs up behind the first result.
    border = pick_border();
    set_geometry(border, 9'd10, 9'd8);
    hold_start = 1'b1;
    queue_image(10, 8, 1'b1, border, ink);
    queue_scans(ink / 2 + 4);
    wait_drained();

    while (items_queued < RUN_ITEMS) begin
      random_phase($urandom_range(1, 12), $urandom_range(1, 10));
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("glyph_region_bounding_boxes regression: pass");
    end else begin
      $display("glyph_region_bounding_boxes regression: fail");
    end
    $finish;
  end

endmodule
